// ===== hw/rtl/rhc_pkg.sv =====
// rhc_pkg: shared types and constants of the readout header checker
// no dependencies; imported by the interfaces and every checker module

package rhc_pkg;

   localparam int WORD_W      = 32;
   localparam int TRIG_W      = 4;
   localparam int STATUS_W    = 3;
   localparam int COUNTER_W   = 4;
   localparam int LEN_W       = 12;
   localparam int COUNT_W     = 6;
   localparam int TTYPE_W     = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   // register indexes on the csr channel
   localparam logic [CSR_INDEX_W-1:0] CSR_BRANCH_INDEX    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULE_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPRESSED_MODE = 2'd2;

   // reset values of the registers
   localparam logic [COUNT_W-1:0] MODULE_COUNT_RESET = 6'd1;

   // trigger type codes carried in header bits 19..16
   localparam logic [TTYPE_W-1:0] TT_COMPRESSED = 2'd1;
   localparam logic [TTYPE_W-1:0] TT_NORMAL     = 2'd2;

   // event trigger number that selects compressed data
   localparam logic [TRIG_W-1:0] TRIG_COMPRESSED = 4'd1;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_BRANCH  = 3'd1,
      ST_CARD    = 3'd2,
      ST_TRIGGER = 3'd3,
      ST_COUNTER = 3'd4
   } status_type;

   typedef struct packed {
      logic               branch_index;
      logic [COUNT_W-1:0] module_count;
      logic               compressed_mode;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      status_type           status;
      logic [COUNTER_W-1:0] counter_expected;
   } result_type;

endpackage

// ===== hw/rtl/rhc_if.sv =====
// rhc_if: valid/ready channel interfaces of the readout header checker
// depends on rhc_pkg for the field widths

interface rhc_req_if import rhc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] data_word;
   logic              event_start;
   logic [TRIG_W-1:0] event_trigger;

   modport source (output valid, data_word, event_start, event_trigger, input ready);
   modport sink   (input valid, data_word, event_start, event_trigger, output ready);
endinterface

interface rhc_rsp_if import rhc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [COUNTER_W-1:0] counter_expected;

   modport source (output valid, status, counter_expected, input ready);
   modport sink   (input valid, status, counter_expected, output ready);
endinterface

interface rhc_csr_if import rhc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// ===== hw/rtl/readout_header_checker_core.sv =====
// readout_header_checker_core: top level of the readout header checker
// depends on rhc_pkg, rhc_if, rhc_csr and rhc_tracker
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   data_word[31:0] event_start event_trigger[3:0]
//   rsp_chan  out  valid/ready   status[2:0] counter_expected[3:0]
//   csr_chan  in   valid/ready   reg_index[1:0] write_data[5:0]
//
// one word per cycle unless rsp_chan stalls; results come from the result register
// the rate is set by the combinational tracker step between input and result registers
// synchronous active-high reset: idle, event counter zero, registers at their defaults
// a stalled result holds in the result register while one more word waits in the
// input register; req_chan.ready drops only when both are full and rsp_chan is stalled

module readout_header_checker_core import rhc_pkg::*; #(
   parameter int MAX_MODULES = 32
) (
   input  logic       clock,
   input  logic       reset,
   rhc_req_if.sink    req_chan,
   rhc_rsp_if.source  rsp_chan,
   rhc_csr_if.sink    csr_chan
);

   cfg_type    cfg;
   result_type res;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_word_ff;
   logic              s1_start_ff;
   logic [TRIG_W-1:0] s1_trig_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [COUNTER_W-1:0] rsp_counter_ff;

   logic out_free;
   logic step;
   logic req_take;

   // the tracker may step whenever the result register can take a result
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   rhc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   rhc_tracker #(
      .MAX_MODULES (MAX_MODULES)
   ) u_tracker (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (step),
      .word  (s1_word_ff),
      .start (s1_start_ff),
      .trig  (s1_trig_ff),
      .res   (res)
   );

   // input stage occupancy
   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // result stage occupancy: a step with no result just drains a taken word
   always_comb begin
      if (step && res.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff  <= req_chan.data_word;
         s1_start_ff <= req_chan.event_start;
         s1_trig_ff  <= req_chan.event_trigger;
      end
      if (step && res.valid) begin
         rsp_status_ff  <= res.status;
         rsp_counter_ff <= res.counter_expected;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.counter_expected = rsp_counter_ff;

   // a waiting word must not be lost or overwritten while the output is blocked
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_word_ff)))
      else $error("input word dropped while the result stage was blocked");

endmodule

// ===== hw/rtl/rhc_csr.sv =====
// rhc_csr: configuration registers of the readout header checker
// depends on rhc_pkg and rhc_csr_if

module rhc_csr import rhc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rhc_csr_if.sink   csr_chan,
   output cfg_type   cfg
);

   logic               branch_ff,   branch_in;
   logic [COUNT_W-1:0] count_ff,    count_in;
   logic               compress_ff, compress_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      branch_in   = branch_ff;
      count_in    = count_ff;
      compress_in = compress_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            CSR_BRANCH_INDEX:    branch_in   = csr_chan.write_data[0];
            CSR_MODULE_COUNT:    count_in    = csr_chan.write_data[COUNT_W-1:0];
            CSR_COMPRESSED_MODE: compress_in = csr_chan.write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         branch_ff   <= 1'b0;
         count_ff    <= MODULE_COUNT_RESET;
         compress_ff <= 1'b0;
      end else begin
         branch_ff   <= branch_in;
         count_ff    <= count_in;
         compress_ff <= compress_in;
      end
   end

   assign cfg.branch_index    = branch_ff;
   assign cfg.module_count    = count_ff;
   assign cfg.compressed_mode = compress_ff;

endmodule

// ===== hw/rtl/rhc_tracker.sv =====
// rhc_tracker: event state machine and header checks, one word per step
// depends on rhc_pkg

module rhc_tracker import rhc_pkg::*; #(
   parameter int MAX_MODULES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              step,
   input  logic [WORD_W-1:0] word,
   input  logic              start,
   input  logic [TRIG_W-1:0] trig,
   output result_type        res
);

   localparam int BD_W = $clog2(MAX_MODULES + 1);
   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_MODULES);

   phase_type            phase_ff,   phase_in;
   logic [COUNTER_W-1:0] counter_ff, counter_in;
   logic [BD_W-1:0]      bd_ff,      bd_in;
   logic [LEN_W-1:0]     skip_ff,    skip_in;
   logic [TTYPE_W-1:0]   ett_ff,     ett_in;

   logic [COUNT_W-1:0]   eff_count;
   logic [TTYPE_W-1:0]   ett_cur;
   logic [BD_W-1:0]      bd_cur;
   logic [BD_W:0]        bd_inc;
   logic                 block_last;
   logic [LEN_W-1:0]     skip_dec;
   logic                 payload_end;
   logic                 empty_event;
   logic                 take_header;
   logic                 len_zero;
   status_type           hdr_status;

   // shared decode
   always_comb begin
      eff_count   = (cfg.module_count > MAX_CNT) ? MAX_CNT : cfg.module_count;
      ett_cur     = start ? ((cfg.compressed_mode && trig == TRIG_COMPRESSED) ?
                             TT_COMPRESSED : TT_NORMAL) : ett_ff;
      bd_cur      = start ? '0 : bd_ff;
      bd_inc      = {1'b0, bd_cur} + (BD_W + 1)'(1);
      block_last  = (COUNT_W + 1)'(bd_inc) >= (COUNT_W + 1)'(eff_count);
      skip_dec    = skip_ff - LEN_W'(1);
      payload_end = (skip_dec == '0);
      empty_event = start && (eff_count == '0);
      take_header = start ? (eff_count != '0) : (phase_ff == PH_HEADER);
      len_zero    = (word[LEN_W-1:0] == '0);
   end

   // header field checks, first failure wins
   always_comb begin
      if (word[27:24] != {3'b000, cfg.branch_index}) begin
         hdr_status = ST_BRANCH;
      end else if (word[23:20] == 4'd0 || {2'b00, word[23:20]} > eff_count) begin
         hdr_status = ST_CARD;
      end else if (word[19:16] != {2'b00, ett_cur}) begin
         hdr_status = ST_TRIGGER;
      end else if (word[15:12] != counter_ff) begin
         hdr_status = ST_COUNTER;
      end else begin
         hdr_status = ST_OK;
      end
   end

   // next state
   always_comb begin
      phase_in   = phase_ff;
      counter_in = counter_ff;
      bd_in      = bd_ff;
      skip_in    = skip_ff;
      ett_in     = ett_ff;
      if (step) begin
         if (start) begin
            ett_in  = ett_cur;
            bd_in   = '0;
            skip_in = '0;
         end
         if (empty_event) begin
            counter_in = counter_ff + COUNTER_W'(1);
            phase_in   = PH_IDLE;
         end else if (take_header) begin
            if (hdr_status != ST_OK) begin
               phase_in = PH_IDLE;
            end else begin
               skip_in = word[LEN_W-1:0];
               if (len_zero) begin
                  bd_in = bd_inc[BD_W-1:0];
                  if (block_last) begin
                     counter_in = counter_ff + COUNTER_W'(1);
                     phase_in   = PH_IDLE;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_PAYLOAD: begin
                  skip_in = skip_dec;
                  if (payload_end) begin
                     bd_in = bd_inc[BD_W-1:0];
                     if (block_last) begin
                        counter_in = counter_ff + COUNTER_W'(1);
                        phase_in   = PH_IDLE;
                     end else begin
                        phase_in = PH_HEADER;
                     end
                  end
               end
               PH_IDLE, PH_HEADER: ;
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // result
   always_comb begin
      res.valid            = 1'b0;
      res.status           = ST_OK;
      res.counter_expected = counter_ff;
      if (step) begin
         if (empty_event) begin
            res.valid = 1'b1;
         end else if (take_header) begin
            if (hdr_status != ST_OK) begin
               res.valid  = 1'b1;
               res.status = hdr_status;
            end else if (len_zero && block_last) begin
               res.valid = 1'b1;
            end
         end else if (phase_ff == PH_PAYLOAD && payload_end && block_last) begin
            res.valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         counter_ff <= '0;
         bd_ff      <= '0;
         skip_ff    <= '0;
         ett_ff     <= TT_NORMAL;
      end else begin
         phase_ff   <= phase_in;
         counter_ff <= counter_in;
         bd_ff      <= bd_in;
         skip_ff    <= skip_in;
         ett_ff     <= ett_in;
      end
   end

   a_ok_advances: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.status == ST_OK) |=> (counter_ff == $past(counter_ff) + 4'd1))
      else $error("event counter did not advance after ok");

   a_fail_idles: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.status != ST_OK) |=> (phase_ff == PH_IDLE))
      else $error("tracker left idle missing after a failure");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (step && !start && phase_ff == PH_IDLE) |-> !res.valid)
      else $error("result produced from a word outside an event");

   a_bd_bound: assert property (@(posedge clock) disable iff (reset)
      (COUNT_W + 1)'(bd_ff) <= (COUNT_W + 1)'(MAX_MODULES))
      else $error("block count beyond module limit");

endmodule
